[hw/rtl/cbsr_pkg.sv]
`timescale 1ns / 1ps

package cbsr_pkg;

  // Unprefixed accumulator rotates: RLCA, RRCA, RLA, RRA match under this mask
  localparam logic [7:0] OP_ACC_ROT_MASK = 8'hE7;
  localparam logic [7:0] OP_ACC_ROT      = 8'h07;

  // Destination code of the accumulator
  localparam logic [2:0] TARGET_A = 3'd7;

  // Flag mask codes: bit3 Z, bit2 N, bit1 H, bit0 C
  localparam logic [3:0] FMASK_ALL  = 4'hF;
  localparam logic [3:0] FMASK_BIT  = 4'hE;
  localparam logic [3:0] FMASK_NONE = 4'h0;

  // Prefixed page group, opcode bits 7..6
  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } group_t;

  // Shift/rotate kind, opcode bits 5..3
  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_kind_t;

  typedef struct packed {
    logic [7:0] operation;
    logic       cb_prefix;
    logic [7:0] operand_value;
    logic       carry_in;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic       write_result;
    logic [2:0] target_sel;
    logic       zero_flag;
    logic       subtract_flag;
    logic       half_flag;
    logic       carry_flag;
    logic [3:0] flag_mask;
    logic       bad_opcode;
  } res_word_t;

endpackage

[hw/rtl/cbsr_if.sv]
`timescale 1ns / 1ps

// Command channel: one instruction word
interface cbsr_cmd_if;
  import cbsr_pkg::*;

  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel: one result word
interface cbsr_res_if;
  import cbsr_pkg::*;

  logic      valid;
  logic      ready;
  res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/cbsr_alu.sv]
`timescale 1ns / 1ps

// Decode and compute: shallow muxing between the input and result registers
module cbsr_alu (
  input  cbsr_pkg::cmd_word_t cmd_word,
  output cbsr_pkg::res_word_t res_word
);
  import cbsr_pkg::*;

  logic [7:0]  v;
  logic [2:0]  sel;
  logic [2:0]  tgt;
  logic [7:0]  bit_sel;
  logic [7:0]  sh_val;
  logic        sh_carry;
  logic        is_acc_rot;
  shift_kind_t kind;
  group_t      grp;

  assign v          = cmd_word.operand_value;
  assign sel        = cmd_word.operation[5:3];
  assign tgt        = cmd_word.operation[2:0];
  assign kind       = shift_kind_t'(sel);
  assign grp        = group_t'(cmd_word.operation[7:6]);
  assign bit_sel    = 8'b1 << sel;
  assign is_acc_rot = (cmd_word.operation & OP_ACC_ROT_MASK) == OP_ACC_ROT;

  // Shift/rotate unit shared by both pages
  always_comb begin
    unique case (kind)
      SH_RLC: begin
        sh_val   = {v[6:0], v[7]};
        sh_carry = v[7];
      end
      SH_RRC: begin
        sh_val   = {v[0], v[7:1]};
        sh_carry = v[0];
      end
      SH_RL: begin
        sh_val   = {v[6:0], cmd_word.carry_in};
        sh_carry = v[7];
      end
      SH_RR: begin
        sh_val   = {cmd_word.carry_in, v[7:1]};
        sh_carry = v[0];
      end
      SH_SLA: begin
        sh_val   = {v[6:0], 1'b0};
        sh_carry = v[7];
      end
      SH_SRA: begin
        sh_val   = {v[7], v[7:1]};
        sh_carry = v[0];
      end
      SH_SWAP: begin
        sh_val   = {v[3:0], v[7:4]};
        sh_carry = 1'b0;
      end
      default: begin
        sh_val   = {1'b0, v[7:1]};
        sh_carry = v[0];
      end
    endcase
  end

  // Result and flags
  always_comb begin
    res_word               = '0;
    res_word.subtract_flag = 1'b0;
    if (!cmd_word.cb_prefix) begin
      if (is_acc_rot) begin
        // accumulator rotates: Z forced low
        res_word.result_value = sh_val;
        res_word.write_result = 1'b1;
        res_word.target_sel   = TARGET_A;
        res_word.carry_flag   = sh_carry;
        res_word.flag_mask    = FMASK_ALL;
      end else begin
        res_word.bad_opcode = 1'b1;
      end
    end else begin
      res_word.target_sel = tgt;
      unique case (grp)
        GRP_SHIFT: begin
          res_word.result_value = sh_val;
          res_word.write_result = 1'b1;
          res_word.zero_flag    = (sh_val == 8'h00);
          res_word.carry_flag   = sh_carry;
          res_word.flag_mask    = FMASK_ALL;
        end
        GRP_BIT: begin
          res_word.result_value = v;
          res_word.zero_flag    = ~v[sel];
          res_word.half_flag    = 1'b1;
          res_word.flag_mask    = FMASK_BIT;
        end
        GRP_RES: begin
          res_word.result_value = v & ~bit_sel;
          res_word.write_result = 1'b1;
          res_word.flag_mask    = FMASK_NONE;
        end
        default: begin
          res_word.result_value = v | bit_sel;
          res_word.write_result = 1'b1;
          res_word.flag_mask    = FMASK_NONE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/cb_bit_shift_rotate_unit.sv]
`timescale 1ns / 1ps

// Bit, shift and rotate unit for the prefixed opcode page and the accumulator
// rotates of the unprefixed page.
// cmd carries one instruction word (opcode, page flag, operand, carry) with a
// valid/ready handshake; res returns one result word per command: new byte,
// write enable, destination, Z/N/H/C and the mask of flags that change.
// Destination 6 means memory at HL; the caller does that access itself.
// From command acceptance to result valid a command passes one input
// register, the decode and compute logic, then the result register.
// Throughput is one word per cycle while the receiver keeps res.ready high;
// both registers advance whenever the stage after them is empty or being
// emptied, so the block takes one more command while a finished result
// waits to be taken.
// When res.ready is low the result holds, the input register fills, and then
// cmd.ready drops until the receiver takes the result.
// Reset clears both valid bits; the data registers are not reset.
module cb_bit_shift_rotate_unit (
  input  logic        clk,
  input  logic        rst,
  cbsr_cmd_if.sink    cmd,
  cbsr_res_if.source  res
);
  import cbsr_pkg::*;

  logic      in_valid;
  cmd_word_t in_word;
  logic      out_valid;
  res_word_t out_word;
  res_word_t alu_word;
  logic      out_load;
  logic      in_load;

  // Handshake: each stage moves when the one after it has room
  assign out_load  = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || out_load;
  assign in_load   = cmd.valid && cmd.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_word <= cmd.data;
    end
  end

  cbsr_alu u_alu (
    .cmd_word (in_word),
    .res_word (alu_word)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= alu_word;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_word;

  // A bad opcode never writes and never touches flags
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.bad_opcode) |->
      (!out_word.write_result && out_word.flag_mask == FMASK_NONE))
    else $error("bad opcode word writes or changes flags");

  // A valid non-writing word that is not bad must be BIT, which sets H
  a_bit_half: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.bad_opcode && !out_word.write_result) |->
      (out_word.half_flag && out_word.flag_mask == FMASK_BIT))
    else $error("non-writing result without BIT flags");

  // A word moved into the result register is valid in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register loaded but not valid");

  // The input register is never overwritten while its word is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_load) |-> !in_load)
    else $error("command accepted over a held word");

  // Accumulator rotates always target A with Z low
  a_acc_rot: assert property (@(posedge clk) disable iff (rst)
    (out_load && !in_word.cb_prefix && !alu_word.bad_opcode) |->
      (alu_word.target_sel == TARGET_A && !alu_word.zero_flag))
    else $error("accumulator rotate with wrong target or Z");

endmodule
